// File: hdl/kl_pkg.sv
// ----------------------------------------------------------------------------
// kl_pkg
// Shared widths, token kind codes, token and queue entry types, and the
// keyword and operator decode functions of the keyword lexer.
// ----------------------------------------------------------------------------
package kl_pkg;

    localparam int CHAR_W          = 8;
    localparam int KIND_W          = 5;
    localparam int TEXT_W          = 56;
    localparam int LEN_W           = 3;
    localparam int VALUE_BITS      = 31;
    localparam int MAX_IDENT_CHARS = 7;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    // token kinds
    localparam logic [KIND_W-1:0] KIND_END      = 5'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN    = 5'd1;
    localparam logic [KIND_W-1:0] KIND_IF       = 5'd2;
    localparam logic [KIND_W-1:0] KIND_THEN     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_WHILE    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_DO       = 5'd5;
    localparam logic [KIND_W-1:0] KIND_KW_END   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd9;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd10;
    localparam logic [KIND_W-1:0] KIND_STAR     = 5'd11;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_COLON    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_LT       = 5'd15;
    localparam logic [KIND_W-1:0] KIND_NE       = 5'd16;
    localparam logic [KIND_W-1:0] KIND_LE       = 5'd17;
    localparam logic [KIND_W-1:0] KIND_GT       = 5'd18;
    localparam logic [KIND_W-1:0] KIND_GE       = 5'd19;
    localparam logic [KIND_W-1:0] KIND_EQ       = 5'd20;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd21;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd22;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd23;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 5'd24;

    // keyword texts, first character in the lowest byte
    localparam logic [TEXT_W-1:0] KW_BEGIN = 56'h6E_69_67_65_62;
    localparam logic [TEXT_W-1:0] KW_IF    = 56'h66_69;
    localparam logic [TEXT_W-1:0] KW_THEN  = 56'h6E_65_68_74;
    localparam logic [TEXT_W-1:0] KW_WHILE = 56'h65_6C_69_68_77;
    localparam logic [TEXT_W-1:0] KW_DO    = 56'h6F_64;
    localparam logic [TEXT_W-1:0] KW_END   = 56'h64_6E_65;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [TEXT_W-1:0]     text;
        logic [LEN_W-1:0]      length;
        logic [VALUE_BITS-1:0] value;
        logic                  ovf;
    } token_t;

    // all tokens caused by one byte
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [KIND_W-1:0] keyword_kind(
        input logic [TEXT_W-1:0] text,
        input logic [LEN_W-1:0]  len,
        input logic              trunc
    );
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        if (!trunc)
        begin
            if (len == 3'd5 && text == KW_BEGIN)
                k = KIND_BEGIN;
            else if (len == 3'd2 && text == KW_IF)
                k = KIND_IF;
            else if (len == 3'd4 && text == KW_THEN)
                k = KIND_THEN;
            else if (len == 3'd5 && text == KW_WHILE)
                k = KIND_WHILE;
            else if (len == 3'd2 && text == KW_DO)
                k = KIND_DO;
            else if (len == 3'd3 && text == KW_END)
                k = KIND_KW_END;
        end
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3D:   k = KIND_EQ;
            8'h3B:   k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

// File: hdl/kl_byte_if.sv
// ----------------------------------------------------------------------------
// kl_byte_if
// Valid/ready channel that carries one source byte per item.
// ----------------------------------------------------------------------------
interface kl_byte_if;
    logic                     valid;
    logic                     ready;
    logic [kl_pkg::CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

// File: hdl/kl_token_if.sv
// ----------------------------------------------------------------------------
// kl_token_if
// Valid/ready channel that carries one token per item.
// ----------------------------------------------------------------------------
interface kl_token_if;
    logic                          valid;
    logic                          ready;
    logic [kl_pkg::KIND_W-1:0]     token_kind;
    logic [kl_pkg::TEXT_W-1:0]     token_text;
    logic [kl_pkg::LEN_W-1:0]      text_length;
    logic [kl_pkg::VALUE_BITS-1:0] number_value;
    logic                          overflow;
    logic                          last_result;

    modport source (output valid, output token_kind, output token_text,
                    output text_length, output number_value, output overflow,
                    output last_result, input ready);
    modport sink   (input valid, input token_kind, input token_text,
                    input text_length, input number_value, input overflow,
                    input last_result, output ready);
endinterface

// File: hdl/keyword_lexer_stream.sv
// ----------------------------------------------------------------------------
// keyword_lexer_stream
// Streaming lexer: source bytes in, identifier, keyword, number, operator,
// error and end tokens out.
// ----------------------------------------------------------------------------
// One source byte is taken per clock on the chars channel; each byte yields
// zero, one or two tokens on the tokens channel, the last of them marked
// with last_result. The scanner decides a byte in the cycle it is accepted
// and pushes its tokens as one entry into a four-entry queue; the output
// stage sends one token per clock, while the receiver takes them, from its
// output register, so a token passes the queue and then the output register.
// The output register is the throughput limit: a byte that completes two
// tokens occupies it for both in turn, and the queue absorbs that until it
// fills, at which point chars.ready drops. Identifiers keep at most seven
// characters (longer ones are truncated, flagged in overflow and never match
// a keyword); numbers saturate at 2^31-1 with overflow set. Byte 0 or '#'
// flushes any pending token, sends an end token and leaves the scanner idle.
// ----------------------------------------------------------------------------
module keyword_lexer_stream (
    input  logic       clk,
    input  logic       rst_n,
    kl_byte_if.sink    chars,
    kl_token_if.source tokens
);
    import kl_pkg::*;

    // scanner to queue
    logic      push;
    entry_t    push_entry;

    // queue to output stage
    logic      pop;
    entry_t    head;
    q_status_t q_stat;

    // classify bytes, hold the pending token
    kl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouple the scanner from output stalls
    kl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    // send tokens one at a time
    kl_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

// File: hdl/kl_front.sv
// ----------------------------------------------------------------------------
// kl_front
// Scanner: takes one byte per cycle while the queue has room, keeps the
// pending token and pushes the one or two tokens it completes into the queue.
// ----------------------------------------------------------------------------
module kl_front (
    input  logic              clk,
    input  logic              rst_n,
    kl_byte_if.sink           chars,
    input  kl_pkg::q_status_t q_stat,
    output logic              push,
    output kl_pkg::entry_t    push_entry
);
    import kl_pkg::*;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_LT     = 3'd3;
    localparam logic [2:0] MODE_GT     = 3'd4;
    localparam logic [2:0] MODE_COLON  = 3'd5;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    localparam int PROD_W = VALUE_BITS + 4;

    logic [2:0]            mode_reg,  mode_next;
    logic [TEXT_W-1:0]     text_reg,  text_next;
    logic [LEN_W-1:0]      len_reg,   len_next;
    logic                  trunc_reg, trunc_next;
    logic [VALUE_BITS-1:0] accum_reg, accum_next;
    logic                  sat_reg,   sat_next;

    logic              accept;
    logic [CHAR_W-1:0] c;
    logic              is_letter, is_digit;
    logic [VALUE_BITS-1:0] acc_base;
    logic [PROD_W-1:0]     prod;
    logic [VALUE_BITS-1:0] acc_new;
    logic                  sat_new;
    logic              has_a, has_b;
    token_t            tok_a, tok_b, flush_tok;
    logic [KIND_W-1:0] ok;

    assign chars.ready = !q_stat.full;
    assign accept      = chars.valid && !q_stat.full;
    assign c           = chars.in_char;
    assign is_letter   = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign is_digit    = (c >= 8'h30 && c <= 8'h39);

    // value*10 + digit, saturating
    always_comb
    begin
        acc_base = (mode_reg == MODE_NUMBER) ? accum_reg : '0;
        prod     = (PROD_W'(acc_base) << 3) + (PROD_W'(acc_base) << 1)
                 + PROD_W'(c - CH_ZERO);
        if (prod > PROD_W'(VALUE_MAX))
        begin
            acc_new = VALUE_MAX;
            sat_new = 1'b1;
        end
        else
        begin
            acc_new = prod[VALUE_BITS-1:0];
            sat_new = (mode_reg == MODE_NUMBER) ? sat_reg : 1'b0;
        end
    end

    // token for whatever is pending
    always_comb
    begin
        flush_tok = '0;
        unique case (mode_reg)
            MODE_IDENT:
            begin
                flush_tok.kind   = keyword_kind(text_reg, len_reg, trunc_reg);
                flush_tok.text   = text_reg;
                flush_tok.length = len_reg;
                flush_tok.ovf    = trunc_reg;
            end
            MODE_NUMBER:
            begin
                flush_tok.kind  = KIND_NUMBER;
                flush_tok.value = accum_reg;
                flush_tok.ovf   = sat_reg;
            end
            MODE_LT:
            begin
                flush_tok.kind   = KIND_LT;
                flush_tok.text   = TEXT_W'(CH_LT);
                flush_tok.length = 3'd1;
            end
            MODE_GT:
            begin
                flush_tok.kind   = KIND_GT;
                flush_tok.text   = TEXT_W'(CH_GT);
                flush_tok.length = 3'd1;
            end
            MODE_COLON:
            begin
                flush_tok.kind   = KIND_COLON;
                flush_tok.text   = TEXT_W'(CH_COLON);
                flush_tok.length = 3'd1;
            end
            default: flush_tok = '0;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        text_next  = text_reg;
        len_next   = len_reg;
        trunc_next = trunc_reg;
        accum_next = accum_reg;
        sat_next   = sat_reg;
        has_a      = 1'b0;
        has_b      = 1'b0;
        tok_a      = flush_tok;
        tok_b      = '0;
        ok         = op_kind(c);

        if (mode_reg == MODE_IDENT && (is_letter || is_digit))
        begin
            // extend or drop past the buffer
            if (len_reg < LEN_W'(MAX_IDENT_CHARS))
            begin
                text_next = text_reg | (TEXT_W'(c) << {len_reg, 3'b000});
                len_next  = len_reg + 3'd1;
            end
            else
                trunc_next = 1'b1;
        end
        else if (mode_reg == MODE_NUMBER && is_digit)
        begin
            accum_next = acc_new;
            sat_next   = sat_new;
        end
        else if (mode_reg == MODE_LT && (c == CH_GT || c == CH_EQ))
        begin
            has_a        = 1'b1;
            tok_a        = '0;
            tok_a.kind   = (c == CH_GT) ? KIND_NE : KIND_LE;
            tok_a.text   = TEXT_W'({c, CH_LT});
            tok_a.length = 3'd2;
            mode_next    = MODE_IDLE;
        end
        else if ((mode_reg == MODE_GT || mode_reg == MODE_COLON) && c == CH_EQ)
        begin
            has_a        = 1'b1;
            tok_a        = '0;
            tok_a.kind   = (mode_reg == MODE_GT) ? KIND_GE : KIND_ASSIGN;
            tok_a.text   = TEXT_W'({CH_EQ, (mode_reg == MODE_GT) ? CH_GT : CH_COLON});
            tok_a.length = 3'd2;
            mode_next    = MODE_IDLE;
        end
        else
        begin
            // flush pending token, then handle the byte on its own
            has_a     = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            if (c == CH_SPACE || c == CH_LF)
                has_b = 1'b0;
            else if (c == CH_NUL || c == CH_HASH)
            begin
                has_b      = 1'b1;
                tok_b.kind = KIND_END;
            end
            else if (is_letter)
            begin
                mode_next  = MODE_IDENT;
                text_next  = TEXT_W'(c);
                len_next   = 3'd1;
                trunc_next = 1'b0;
            end
            else if (is_digit)
            begin
                mode_next  = MODE_NUMBER;
                accum_next = acc_new;
                sat_next   = sat_new;
            end
            else if (c == CH_LT)
                mode_next = MODE_LT;
            else if (c == CH_GT)
                mode_next = MODE_GT;
            else if (c == CH_COLON)
                mode_next = MODE_COLON;
            else
            begin
                has_b      = 1'b1;
                tok_b.kind = ok;
                if (ok != KIND_ERROR)
                begin
                    tok_b.text   = TEXT_W'(c);
                    tok_b.length = 3'd1;
                end
            end
        end

        push              = accept && (has_a || has_b);
        push_entry.two    = has_a && has_b;
        push_entry.first  = has_a ? tok_a : tok_b;
        push_entry.second = tok_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            text_reg  <= '0;
            len_reg   <= '0;
            trunc_reg <= 1'b0;
            accum_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            text_reg  <= text_next;
            len_reg   <= len_next;
            trunc_reg <= trunc_next;
            accum_reg <= accum_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

// File: hdl/kl_queue.sv
// ----------------------------------------------------------------------------
// kl_queue
// Small FIFO of token entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
module kl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kl_pkg::entry_t     push_entry,
    input  logic               pop,
    output kl_pkg::entry_t     head,
    output kl_pkg::q_status_t  stat
);
    import kl_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
        stat.empty  = (count_reg == '0);
        stat.full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
        head        = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into full token queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty token queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// File: hdl/kl_back.sv
// ----------------------------------------------------------------------------
// kl_back
// Output stage: unpacks queue entries into single tokens and holds each in
// the output register until taken.
// ----------------------------------------------------------------------------
module kl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  kl_pkg::entry_t    head,
    input  kl_pkg::q_status_t q_stat,
    output logic              pop,
    kl_token_if.source        tokens
);
    import kl_pkg::*;

    logic   out_valid_reg, out_valid_next;
    logic   sel_reg,       sel_next;
    token_t out_tok_reg;
    logic   out_last_reg;

    logic   load;
    token_t cur;
    logic   is_last;

    always_comb
    begin
        load           = !out_valid_reg || tokens.ready;
        cur            = sel_reg ? head.second : head.first;
        is_last        = sel_reg || !head.two;
        pop            = load && !q_stat.empty && is_last;
        out_valid_next = load ? !q_stat.empty : out_valid_reg;
        sel_next       = (load && !q_stat.empty) ? !is_last : sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_stat.empty)
        begin
            out_tok_reg  <= cur;
            out_last_reg <= is_last;
        end
    end

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_kind   = out_tok_reg.kind;
    assign tokens.token_text   = out_tok_reg.text;
    assign tokens.text_length  = out_tok_reg.length;
    assign tokens.number_value = out_tok_reg.value;
    assign tokens.overflow     = out_tok_reg.ovf;
    assign tokens.last_result  = out_last_reg;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyword lexer. Source bytes go in on the chars
// channel under random bursts and gaps, and tokens come out on the tokens
// channel under a shifting stall pattern. An in-bench scanner predicts the
// tokens of every accepted byte. Each delivered token is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import kl_pkg::*;

    // scanner modes of the in-bench lexer
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_LT,
        SCAN_GT,
        SCAN_COLON
    } scan_t;

    // one predicted token, with its end-of-byte mark
    typedef struct packed {
        token_t tok;
        logic   last;
    } lexeme_t;

    // directed stimulus: a byte, and where typed, the last token it must give
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              typed;
        logic [KIND_W-1:0] kind;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
    } probe_row_t;

    localparam int PROBE_ROWS  = 24;
    localparam int RANDOM_MIN  = 500;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 120;
    localparam int DRAIN_AT    = 300;

    logic clk;
    logic rst_n;

    kl_byte_if  chars ();
    kl_token_if tokens ();

    keyword_lexer_stream dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars.sink),
        .tokens (tokens.source)
    );

    // predictor state
    scan_t                 scan_mode;
    logic [TEXT_W-1:0]     word_text;
    logic [LEN_W-1:0]      word_len;
    logic                  word_cut;
    logic [VALUE_BITS-1:0] num_acc;
    logic                  num_sat;

    lexeme_t           expected_tokens [$];
    logic [CHAR_W-1:0] source_text [$];
    int                mismatches;
    int                burst_left;
    bit                hold_req;

    string kw_words [6] = '{"begin", "if", "then", "while", "do", "end"};
    string op_words [15] = '{"+", "-", "*", "/", ":", ":=", "<", "<>", "<=", ">", ">=",
                             "=", ";", "(", ")"};

    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{8'h23, 1'b1, KIND_END,    56'h0,      3'd0},  // '#' from reset
        '{8'h00, 1'b1, KIND_END,    56'h0,      3'd0},  // NUL
        '{"+",   1'b1, KIND_PLUS,   56'h2B,     3'd1},
        '{"b",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"e",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"g",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"i",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"n",   1'b0, KIND_END,    56'h0,      3'd0},
        '{" ",   1'b1, KIND_BEGIN,  KW_BEGIN,   3'd5},
        '{"<",   1'b0, KIND_END,    56'h0,      3'd0},
        '{">",   1'b1, KIND_NE,     56'h3E3C,   3'd2},
        '{":",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"=",   1'b1, KIND_ASSIGN, 56'h3D3A,   3'd2},
        '{">",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"=",   1'b1, KIND_GE,     56'h3D3E,   3'd2},
        '{"x",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"1",   1'b0, KIND_END,    56'h0,      3'd0},
        '{";",   1'b1, KIND_SEMI,   56'h3B,     3'd1},  // identifier flushed first
        '{8'hFF, 1'b1, KIND_ERROR,  56'h0,      3'd0},
        '{8'h09, 1'b1, KIND_ERROR,  56'h0,      3'd0},  // tab is no separator
        '{8'h80, 1'b1, KIND_ERROR,  56'h0,      3'd0},
        '{"\n",  1'b0, KIND_END,    56'h0,      3'd0},
        '{"7",   1'b0, KIND_END,    56'h0,      3'd0},
        '{"#",   1'b1, KIND_END,    56'h0,      3'd0}   // number flushed first
    };

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic bit is_letter(input logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // kind of a one-character operator that never pairs; error for the rest
    function automatic logic [KIND_W-1:0] single_op(input logic [CHAR_W-1:0] c);
        case (c)
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "=":     return KIND_EQ;
            ";":     return KIND_SEMI;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            default: return KIND_ERROR;
        endcase
    endfunction

    // true for a byte that starts no token and separates nothing
    function automatic bit is_error_byte(input logic [CHAR_W-1:0] c);
        if (is_letter(c) || is_digit(c))
            return 0;
        if (c == " " || c == "\n" || c == 8'h00 || c == "#")
            return 0;
        if (c == "<" || c == ">" || c == ":")
            return 0;
        return single_op(c) == KIND_ERROR;
    endfunction

    function automatic token_t make_tok(
        input logic [KIND_W-1:0]     kind,
        input logic [TEXT_W-1:0]     text,
        input logic [LEN_W-1:0]      len,
        input logic [VALUE_BITS-1:0] value,
        input logic                  ovf
    );
        token_t t;
        t.kind   = kind;
        t.text   = text;
        t.length = len;
        t.value  = value;
        t.ovf    = ovf;
        return t;
    endfunction

    // keyword match of the collected word; a truncated word never matches
    function automatic logic [KIND_W-1:0] word_kind();
        logic [TEXT_W-1:0] packed_word;
        for (int k = 0; k < 6; k++)
        begin
            packed_word = '0;
            for (int i = 0; i < kw_words[k].len(); i++)
                packed_word[8*i +: 8] = kw_words[k][i];
            if (!word_cut && word_len == kw_words[k].len() && word_text == packed_word)
                return KIND_BEGIN + k[KIND_W-1:0];
        end
        return KIND_IDENT;
    endfunction

    // accumulate one decimal digit, saturating at the top of the value range
    function automatic void add_digit(input logic [CHAR_W-1:0] c);
        longint unsigned d;
        longint unsigned top;
        d   = 64'(c) - 64'h30;
        top = 64'(VALUE_MAX);
        if (num_acc > (top - d) / 10)
        begin
            num_acc = VALUE_MAX;
            num_sat = 1'b1;
        end
        else
            num_acc = VALUE_BITS'(num_acc * 10 + d[VALUE_BITS-1:0]);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: advance the scanner by one byte, return its tokens
    // ------------------------------------------------------------------
    function automatic int lex_byte(input logic [CHAR_W-1:0] c, output lexeme_t res [2]);
        int n;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (scan_mode == SCAN_IDENT && (is_letter(c) || is_digit(c)))
        begin
            // extend the word; drop characters past the buffer
            if (word_len < MAX_IDENT_CHARS)
            begin
                word_text[8*word_len +: 8] = c;
                word_len++;
            end
            else
                word_cut = 1'b1;
            return 0;
        end
        if (scan_mode == SCAN_NUMBER && is_digit(c))
        begin
            add_digit(c);
            return 0;
        end
        if (scan_mode == SCAN_LT && (c == ">" || c == "="))
        begin
            res[0].tok = make_tok(c == ">" ? KIND_NE : KIND_LE, {c, 8'h3C}, 3'd2, '0, 1'b0);
            n = 1;
            scan_mode = SCAN_IDLE;
        end
        else if ((scan_mode == SCAN_GT || scan_mode == SCAN_COLON) && c == "=")
        begin
            res[0].tok = make_tok(scan_mode == SCAN_GT ? KIND_GE : KIND_ASSIGN,
                                  {8'h3D, scan_mode == SCAN_GT ? 8'h3E : 8'h3A},
                                  3'd2, '0, 1'b0);
            n = 1;
            scan_mode = SCAN_IDLE;
        end
        else
        begin
            // flush whatever is pending, then handle the byte on its own
            case (scan_mode)
                SCAN_IDENT:
                begin
                    res[n].tok = make_tok(word_kind(), word_text, word_len, '0, word_cut);
                    n++;
                end
                SCAN_NUMBER:
                begin
                    res[n].tok = make_tok(KIND_NUMBER, '0, '0, num_acc, num_sat);
                    n++;
                end
                SCAN_LT:
                begin
                    res[n].tok = make_tok(KIND_LT, 56'h3C, 3'd1, '0, 1'b0);
                    n++;
                end
                SCAN_GT:
                begin
                    res[n].tok = make_tok(KIND_GT, 56'h3E, 3'd1, '0, 1'b0);
                    n++;
                end
                SCAN_COLON:
                begin
                    res[n].tok = make_tok(KIND_COLON, 56'h3A, 3'd1, '0, 1'b0);
                    n++;
                end
                default: ;
            endcase
            scan_mode = SCAN_IDLE;
            if (c == " " || c == "\n")
                ;
            else if (c == 8'h00 || c == "#")
            begin
                res[n].tok = make_tok(KIND_END, '0, '0, '0, 1'b0);
                n++;
            end
            else if (is_letter(c))
            begin
                scan_mode = SCAN_IDENT;
                word_text = {48'h0, c};
                word_len  = 3'd1;
                word_cut  = 1'b0;
            end
            else if (is_digit(c))
            begin
                scan_mode = SCAN_NUMBER;
                num_acc   = '0;
                num_sat   = 1'b0;
                add_digit(c);
            end
            else if (c == "<")
                scan_mode = SCAN_LT;
            else if (c == ">")
                scan_mode = SCAN_GT;
            else if (c == ":")
                scan_mode = SCAN_COLON;
            else if (single_op(c) == KIND_ERROR)
            begin
                res[n].tok = make_tok(KIND_ERROR, '0, '0, '0, 1'b0);
                n++;
            end
            else
            begin
                res[n].tok = make_tok(single_op(c), {48'h0, c}, 3'd1, '0, 1'b0);
                n++;
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Random source text: mostly well-formed tokens, some noise
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return r < 26 ? 8'h61 + r[7:0] : 8'h41 + r[7:0] - 8'd26;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic void push_word(input string s);
        for (int i = 0; i < s.len(); i++)
            source_text.push_back(s[i]);
    endfunction

    function automatic void build_source();
        int                r;
        int                len;
        logic [CHAR_W-1:0] c;
        while (source_text.size() < RANDOM_MIN)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                // keyword, now and then with a letter glued on so it is no keyword
                push_word(kw_words[$urandom_range(0, 5)]);
                if ($urandom_range(0, 3) == 0)
                    source_text.push_back(rand_letter());
            end
            else if (r < 35)
            begin
                // identifier; a few run past the buffer
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                source_text.push_back(rand_letter());
                for (int i = 1; i < len; i++)
                    source_text.push_back($urandom_range(0, 2) == 0 ? rand_digit()
                                                                   : rand_letter());
            end
            else if (r < 50)
            begin
                // number; most long ones saturate, the edge values sit on the limit
                len = 0;
                case ($urandom_range(0, 7))
                    0: push_word("2147483647");
                    1: push_word("2147483648");
                    2: len = $urandom_range(10, 13);
                    default: len = $urandom_range(1, 5);
                endcase
                if (source_text.size() == 0 || is_digit(source_text[$]) == 0 ||
                    len != 0)
                    for (int i = 0; i < len; i++)
                        source_text.push_back(rand_digit());
                len = 0;
            end
            else if (r < 75)
                push_word(op_words[$urandom_range(0, 14)]);
            else if (r < 83)
                source_text.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
            else if (r < 88)
                source_text.push_back($urandom_range(0, 1) ? 8'h00 : 8'h23);
            else if (r < 94)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (!is_error_byte(c));
                source_text.push_back(c);
            end
            else
                source_text.push_back(8'($urandom_range(0, 255)));
            // half the tokens stand right against the next one, forcing flushes
            if ($urandom_range(0, 1) == 0)
                source_text.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
        end
        // close the stream so any pending token is flushed and checked
        source_text.push_back(8'h23);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one byte in a burst, wait for it to be taken, predict
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic typed, input token_t tok);
        lexeme_t res [2];
        int      n;
        if (burst_left == 0)
        begin
            // drop valid for a gap, then start a new burst
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        chars.valid   <= 1'b1;
        chars.in_char <= c;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        burst_left--;
        n = lex_byte(c, res);
        if (typed)
        begin
            if (n == 0)
            begin
                $error("directed byte 0x%0h predicts no token", c);
                mismatches++;
            end
            else
                res[n-1].tok = tok;
        end
        for (int i = 0; i < n; i++)
            expected_tokens.push_back(res[i]);
    endtask

    // hold the input low until every predicted token has come out
    task automatic drain_tokens();
        chars.valid <= 1'b0;
        burst_left = 0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compare one delivered token with the oldest prediction
    task automatic check_token();
        lexeme_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("token kind %0d delivered with no prediction pending", tokens.token_kind);
            mismatches++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            check_field("token_kind",   want.tok.kind,   tokens.token_kind);
            check_field("token_text",   want.tok.text,   tokens.token_text);
            check_field("text_length",  want.tok.length, tokens.text_length);
            check_field("number_value", want.tok.value,  tokens.number_value);
            check_field("overflow",     want.tok.ovf,    tokens.overflow);
            check_field("last_result",  want.last,       tokens.last_result);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: check each accepted token, then pick ready for the next
    // cycle. The stall pattern shifts among four modes; once, on request
    // from the sender, ready is held low for a long stretch so the block
    // fills up and drops chars.ready.
    // ------------------------------------------------------------------
    initial
    begin
        logic nr;
        int   cyc;
        int   stall_mode;
        int   hold_left;
        bit   hold_done;
        tokens.ready = 1'b0;
        cyc        = 0;
        stall_mode = 0;
        hold_left  = 0;
        hold_done  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (tokens.valid && tokens.ready)
                check_token();
            cyc++;
            if (cyc % 40 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nr = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       nr = 1'b1;                         // no stalls
                    1:       nr = $urandom_range(0, 3) != 0;    // light stalls
                    2:       nr = $urandom_range(0, 9) < 3;     // heavy stalls
                    default: nr = (cyc % 4) == 0;               // one in four
                endcase
            end
            tokens.ready <= nr;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random stream, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        token_t row_tok;
        chars.valid   = 1'b0;
        chars.in_char = '0;
        rst_n         = 1'b0;
        mismatches    = 0;
        burst_left    = 0;
        hold_req      = 0;
        scan_mode     = SCAN_IDLE;
        word_text     = '0;
        word_len      = '0;
        word_cut      = 1'b0;
        num_acc       = '0;
        num_sat       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: typed rows carry the token they must end with
        for (int i = 0; i < PROBE_ROWS; i++)
        begin
            row_tok = make_tok(probe_rows[i].kind, probe_rows[i].text, probe_rows[i].len,
                               '0, 1'b0);
            send_byte(probe_rows[i].ch, probe_rows[i].typed, row_tok);
        end
        drain_tokens();

        // random part, with one long receiver hold-off and one full drain
        build_source();
        for (int i = 0; i < source_text.size(); i++)
        begin
            if (i == HOLD_AT)
                hold_req = 1;
            if (i == DRAIN_AT)
                drain_tokens();
            send_byte(source_text[i], 1'b0, '0);
        end
        chars.valid <= 1'b0;

        // wait out the last tokens, then keep watching for strays
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
